FILE: hw/rtl/real_number_literal_checker_defines.svh
// Assertion macros for the real-number literal checker.
// Used by the port checker; no other dependencies.
`ifndef REAL_NUMBER_LITERAL_CHECKER_DEFINES_SVH
`define REAL_NUMBER_LITERAL_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on aclk, quiet during reset.
`define RNLC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet during reset.
`define RNLC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/rnlc_pkg.sv
// Shared types, state codes, character codes and the transition function
// of the real-number literal recognizer. No dependencies.
package rnlc_pkg;

    typedef logic [3:0] state_t;
    typedef logic [7:0] char_t;

    localparam state_t ST_START   = 4'd0;
    localparam state_t ST_DEAD    = 4'd1;
    localparam state_t ST_SIGN    = 4'd2;
    localparam state_t ST_INT     = 4'd3;
    localparam state_t ST_ZERO    = 4'd4;
    localparam state_t ST_POINT   = 4'd5;
    localparam state_t ST_FRAC    = 4'd6;
    localparam state_t ST_EXPMARK = 4'd7;
    localparam state_t ST_EXPSIGN = 4'd8;
    localparam state_t ST_EXPNUM  = 4'd9;

    localparam char_t CH_POINT = 8'h2E;
    localparam char_t CH_UPPER_E = 8'h45;
    localparam char_t CH_LOWER_E = 8'h65;
    localparam char_t CH_PLUS  = 8'h2B;
    localparam char_t CH_MINUS = 8'h2D;
    localparam char_t CH_ZERO  = 8'h30;
    localparam char_t CH_ONE   = 8'h31;
    localparam char_t CH_NINE  = 8'h39;

    // Verdict pushed from the recognizer into the output buffer.
    typedef struct packed {
        logic vld;
        logic accepted;
    } result_t;

    function automatic state_t next_state(input state_t s, input char_t c);
        logic digit;
        logic lead;
        logic sign;
        logic expo;
        logic point;
        logic zero;
        state_t n;
        digit = (c >= CH_ZERO) && (c <= CH_NINE);
        lead  = (c >= CH_ONE) && (c <= CH_NINE);
        sign  = (c == CH_PLUS) || (c == CH_MINUS);
        expo  = (c == CH_UPPER_E) || (c == CH_LOWER_E);
        point = (c == CH_POINT);
        zero  = (c == CH_ZERO);
        n = ST_DEAD;
        case (s)
            ST_START: begin
                if (lead)      n = ST_INT;
                else if (sign) n = ST_SIGN;
                else if (zero) n = ST_ZERO;
            end
            ST_SIGN: begin
                if (lead)      n = ST_INT;
                else if (zero) n = ST_ZERO;
            end
            ST_INT: begin
                if (point)      n = ST_POINT;
                else if (expo)  n = ST_EXPMARK;
                else if (digit) n = ST_INT;
            end
            ST_ZERO: begin
                if (point) n = ST_POINT;
            end
            ST_POINT: begin
                if (digit) n = ST_FRAC;
            end
            ST_FRAC: begin
                if (expo)       n = ST_EXPMARK;
                else if (digit) n = ST_FRAC;
            end
            ST_EXPMARK: begin
                if (sign)      n = ST_EXPSIGN;
                else if (lead) n = ST_EXPNUM;
            end
            ST_EXPSIGN: begin
                if (lead) n = ST_EXPNUM;
            end
            ST_EXPNUM: begin
                if (digit) n = ST_EXPNUM;
            end
            default: begin
                n = ST_DEAD;
            end
        endcase
        return n;
    endfunction

    function automatic logic is_final(input state_t s);
        return (s == ST_INT) || (s == ST_ZERO) || (s == ST_FRAC) || (s == ST_EXPNUM);
    endfunction

endpackage

FILE: hw/rtl/rnlc_fsm.sv
// Recognizer state register and one-character transition step.
// Uses rnlc_pkg for state codes and the transition function.
module rnlc_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  rnlc_pkg::char_t   symbol,
    input  logic              last_char,
    output rnlc_pkg::result_t res
);

    rnlc_pkg::state_t state_reg;
    rnlc_pkg::state_t state_next;
    rnlc_pkg::state_t stepped;

    always_comb begin
        stepped    = rnlc_pkg::next_state(state_reg, symbol);
        state_next = state_reg;
        if (step) begin
            // end of string: report and go back to start
            state_next = last_char ? rnlc_pkg::ST_START : stepped;
        end
        res.vld      = step && last_char;
        res.accepted = rnlc_pkg::is_final(stepped);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rnlc_pkg::ST_START;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/rnlc_out_buf.sv
// Output register with a skid entry for the verdict channel.
// Uses rnlc_pkg::result_t.
module rnlc_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  rnlc_pkg::result_t push,
    output logic              room,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_accepted
);

    logic out_vld_reg;
    logic out_vld_next;
    logic out_acc_reg;
    logic out_acc_next;
    logic skid_vld_reg;
    logic skid_vld_next;
    logic skid_acc_reg;
    logic skid_acc_next;
    logic pop;

    assign pop        = out_vld_reg && m_ready;
    assign room       = !skid_vld_reg;
    assign m_valid    = out_vld_reg;
    assign m_accepted = out_acc_reg;

    always_comb begin
        out_vld_next  = out_vld_reg;
        out_acc_next  = out_acc_reg;
        skid_vld_next = skid_vld_reg;
        skid_acc_next = skid_acc_reg;
        if (skid_vld_reg) begin
            // no push while skid is full
            if (pop) begin
                out_acc_next  = skid_acc_reg;
                skid_vld_next = 1'b0;
            end
        end else if (push.vld) begin
            if (!out_vld_reg || pop) begin
                out_vld_next = 1'b1;
                out_acc_next = push.accepted;
            end else begin
                skid_vld_next = 1'b1;
                skid_acc_next = push.accepted;
            end
        end else if (pop) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
        out_acc_reg  <= out_acc_next;
        skid_acc_reg <= skid_acc_next;
    end

endmodule

FILE: hw/rtl/real_number_literal_checker.sv
// Real-number literal checker: one character per request, verdict on the last.
// Path: the last character passes the input register, then its verdict the output register,
// before the verdict shows on m_valid; a full output buffer can stall it in between.
// Throughput: one character per cycle while no last character waits for room in the output buffer.
// Reset: aresetn synchronous, active low; recognizer returns to start, buffers empty.
module real_number_literal_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_symbol,
    input  logic       s_last_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_accepted
);

    // Input register stage: holds one character request.
    logic            in_vld_reg;
    logic            in_vld_next;
    logic [7:0]      in_sym_reg;
    logic [7:0]      in_sym_next;
    logic            in_last_reg;
    logic            in_last_next;

    logic              in_fire;   // input stage hands its character to the recognizer
    logic              s_fire;    // new request taken from the port
    logic              buf_room;  // output buffer can take one more verdict
    rnlc_pkg::result_t verdict;

    // A middle character never waits; a last character needs a free slot
    // in the output buffer (output register plus skid entry).
    assign in_fire = in_vld_reg && (!in_last_reg || buf_room);
    assign s_ready = !in_vld_reg || in_fire;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_vld_next  = in_vld_reg;
        in_sym_next  = in_sym_reg;
        in_last_next = in_last_reg;
        if (s_fire) begin
            in_vld_next  = 1'b1;
            in_sym_next  = s_symbol;
            in_last_next = s_last_char;
        end else if (in_fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
        in_sym_reg  <= in_sym_next;
        in_last_reg <= in_last_next;
    end

    // Ten-state recognizer; state advances on every handed-over character.
    rnlc_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_fire),
        .symbol    (in_sym_reg),
        .last_char (in_last_reg),
        .res       (verdict)
    );

    // Verdict output register with skid entry, so the input side keeps
    // moving while a verdict waits for m_ready.
    rnlc_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (verdict),
        .room       (buf_room),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_accepted (m_accepted)
    );

endmodule

FILE: hw/rtl/rnlc_checker.sv
// Port-level checks for real_number_literal_checker, attached by bind.
// Uses the macros in real_number_literal_checker_defines.svh.
`include "real_number_literal_checker_defines.svh"

module rnlc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_accepted
);

    // stalled verdict holds
    `RNLC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_accepted), "verdict dropped or changed while stalled")
    // with nothing pending at the output, the input side must be open
    `RNLC_ASSERT_NOW(a_ready_when_empty, !m_valid, s_ready, "input blocked with empty output")
    // no verdict straight out of reset
    `RNLC_ASSERT_NOW(a_no_out_after_reset, $rose(aresetn), !m_valid && s_ready, "activity right after reset")
    // no verdict can appear out of an idle input with nothing shown at the output
    `RNLC_ASSERT_NOW(a_no_spurious_out, !$past(s_valid) && !$past(s_valid, 2) && !$past(m_valid), !m_valid, "verdict without a request")

endmodule

bind real_number_literal_checker rnlc_checker u_rnlc_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for real_number_literal_checker: character requests in, verdicts out.
// Depends on rnlc_pkg for the state and character codes. The expected verdicts come from
// an independent recognizer kept in a small scoreboard class.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Character classes seen by the recognizer. Every digit is either LEAD or ZERO.
    typedef enum logic [2:0] {
        K_OTHER,
        K_LEAD,
        K_ZERO,
        K_SIGN,
        K_EXP,
        K_POINT
    } char_kind_t;

    localparam int RANDOM_CHARS = 1150;
    localparam int HOLD_CYCLES  = 250;   // long receiver hold-off, fills the block
    localparam int MAX_REPORTS  = 10;

    // ------------------------------------------------------------------
    // Scoreboard: tracks the literal recognizer state from accepted
    // character requests and holds the verdicts still owed by the block.
    // ------------------------------------------------------------------
    class verdict_scoreboard;
        rnlc_pkg::state_t lit_state;
        bit               expected_verdicts[$];
        int               errors;
        int               chars_seen;
        int               strings_seen;
        int               verdicts_checked;
        int               literals_accepted;

        function new();
            lit_state         = rnlc_pkg::ST_START;
            errors            = 0;
            chars_seen        = 0;
            strings_seen      = 0;
            verdicts_checked  = 0;
            literals_accepted = 0;
        endfunction

        // One step of the recognizer: classify the byte, then walk the table.
        function rnlc_pkg::state_t advance(rnlc_pkg::state_t s, rnlc_pkg::char_t c);
            char_kind_t       k;
            rnlc_pkg::state_t n;
            if (c == rnlc_pkg::CH_ZERO)
                k = K_ZERO;
            else if (c >= rnlc_pkg::CH_ONE && c <= rnlc_pkg::CH_NINE)
                k = K_LEAD;
            else if (c == rnlc_pkg::CH_PLUS || c == rnlc_pkg::CH_MINUS)
                k = K_SIGN;
            else if (c == rnlc_pkg::CH_UPPER_E || c == rnlc_pkg::CH_LOWER_E)
                k = K_EXP;
            else if (c == rnlc_pkg::CH_POINT)
                k = K_POINT;
            else
                k = K_OTHER;
            n = rnlc_pkg::ST_DEAD;
            case (s)
                rnlc_pkg::ST_START: begin
                    if (k == K_LEAD)      n = rnlc_pkg::ST_INT;
                    else if (k == K_SIGN) n = rnlc_pkg::ST_SIGN;
                    else if (k == K_ZERO) n = rnlc_pkg::ST_ZERO;
                end
                rnlc_pkg::ST_SIGN: begin
                    if (k == K_LEAD)      n = rnlc_pkg::ST_INT;
                    else if (k == K_ZERO) n = rnlc_pkg::ST_ZERO;
                end
                rnlc_pkg::ST_INT: begin
                    if (k == K_POINT)                     n = rnlc_pkg::ST_POINT;
                    else if (k == K_EXP)                  n = rnlc_pkg::ST_EXPMARK;
                    else if (k == K_LEAD || k == K_ZERO)  n = rnlc_pkg::ST_INT;
                end
                rnlc_pkg::ST_ZERO: begin
                    if (k == K_POINT) n = rnlc_pkg::ST_POINT;
                end
                rnlc_pkg::ST_POINT: begin
                    if (k == K_LEAD || k == K_ZERO) n = rnlc_pkg::ST_FRAC;
                end
                rnlc_pkg::ST_FRAC: begin
                    if (k == K_EXP)                       n = rnlc_pkg::ST_EXPMARK;
                    else if (k == K_LEAD || k == K_ZERO)  n = rnlc_pkg::ST_FRAC;
                end
                rnlc_pkg::ST_EXPMARK: begin
                    if (k == K_SIGN)      n = rnlc_pkg::ST_EXPSIGN;
                    else if (k == K_LEAD) n = rnlc_pkg::ST_EXPNUM;
                end
                rnlc_pkg::ST_EXPSIGN: begin
                    if (k == K_LEAD) n = rnlc_pkg::ST_EXPNUM;
                end
                rnlc_pkg::ST_EXPNUM: begin
                    if (k == K_LEAD || k == K_ZERO) n = rnlc_pkg::ST_EXPNUM;
                end
                default: begin
                    n = rnlc_pkg::ST_DEAD;
                end
            endcase
            return n;
        endfunction

        // Accepted input request: advance, and on the last character owe a verdict.
        function void note_char(rnlc_pkg::char_t c, logic last);
            rnlc_pkg::state_t n;
            bit               ok;
            n = advance(lit_state, c);
            chars_seen++;
            if (last) begin
                ok = (n == rnlc_pkg::ST_INT) || (n == rnlc_pkg::ST_ZERO)
                  || (n == rnlc_pkg::ST_FRAC) || (n == rnlc_pkg::ST_EXPNUM);
                expected_verdicts.push_back(ok);
                strings_seen++;
                if (ok) literals_accepted++;
                lit_state = rnlc_pkg::ST_START;
            end else begin
                lit_state = n;
            end
        endfunction

        // Accepted result request: compare with the oldest owed verdict.
        function void check_verdict(logic got);
            bit want;
            if (expected_verdicts.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("ERROR %0t: verdict %0b with none expected", $realtime, got);
                errors++;
            end else begin
                want = expected_verdicts.pop_front();
                verdicts_checked++;
                if (got !== want) begin
                    if (errors < MAX_REPORTS)
                        $display("ERROR %0t: verdict %0d expected accepted=%0b got %0b",
                                 $realtime, verdicts_checked, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, DUT signals and instance
    // ------------------------------------------------------------------
    logic            aclk = 1'b0;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    rnlc_pkg::char_t s_symbol;
    logic            s_last_char;
    logic            m_valid;
    logic            m_ready;
    logic            m_accepted;

    always #1 aclk = ~aclk;

    real_number_literal_checker u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_symbol    (s_symbol),
        .s_last_char (s_last_char),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_accepted  (m_accepted)
    );

    verdict_scoreboard sb;

    // Sender state; hold_reqs is also read by the receiver.
    int              hold_reqs = 0;  // bumped by the sender, each one asks for one long hold-off
    rnlc_pkg::char_t word_q[$];      // characters of the string being sent
    int              chars_sent;
    int              burst_left;

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge. Input first;
    // a character accepted now cannot produce a verdict in the same cycle.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_char(s_symbol, s_last_char);
            if (m_valid && m_ready) sb.check_verdict(m_accepted);
        end
    end

    // ------------------------------------------------------------------
    // Sender helpers. Inputs change on the falling edge only.
    // ------------------------------------------------------------------

    // Offer one character request and hold it until accepted. Valid stays high
    // into the next request unless the burst ends, then a random gap follows.
    task automatic push_char(input rnlc_pkg::char_t c, input logic last);
        int unsigned gap;
        @(negedge aclk);
        s_valid     = 1'b1;
        s_symbol    = c;
        s_last_char = last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        chars_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 6);
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap) @(posedge aclk);
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Send word_q as one string, last flag on its final character.
    task automatic send_word();
        int i;
        for (i = 0; i < word_q.size(); i++)
            push_char(word_q[i], i == word_q.size() - 1);
        word_q.delete();
    endtask

    task automatic send_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++) word_q.push_back(rnlc_pkg::char_t'(txt[i]));
        send_word();
    endtask

    task automatic add_digits(input int unsigned count);
        int unsigned i;
        for (i = 0; i < count; i++)
            word_q.push_back(rnlc_pkg::CH_ZERO + rnlc_pkg::char_t'($urandom_range(0, 9)));
    endtask

    // Well-formed literal with random content; sizes kept small.
    task automatic build_literal();
        int unsigned pick;
        pick = $urandom_range(0, 2);
        if (pick == 1) word_q.push_back(rnlc_pkg::CH_PLUS);
        else if (pick == 2) word_q.push_back(rnlc_pkg::CH_MINUS);
        if ($urandom_range(0, 3) == 0) begin
            word_q.push_back(rnlc_pkg::CH_ZERO);
        end else begin
            word_q.push_back(rnlc_pkg::CH_ONE + rnlc_pkg::char_t'($urandom_range(0, 8)));
            add_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 1) == 1) begin
            word_q.push_back(rnlc_pkg::CH_POINT);
            add_digits($urandom_range(1, 4));
        end
        // an exponent needs a digit before it, a bare zero cannot take one
        if ($urandom_range(0, 9) < 4 && !(word_q[word_q.size() - 1] == rnlc_pkg::CH_ZERO
                                           && word_q.size() <= 2)) begin
            word_q.push_back($urandom_range(0, 1) ? rnlc_pkg::CH_UPPER_E
                                                  : rnlc_pkg::CH_LOWER_E);
            pick = $urandom_range(0, 2);
            if (pick == 1) word_q.push_back(rnlc_pkg::CH_PLUS);
            else if (pick == 2) word_q.push_back(rnlc_pkg::CH_MINUS);
            word_q.push_back(rnlc_pkg::CH_ONE + rnlc_pkg::char_t'($urandom_range(0, 8)));
            add_digits($urandom_range(0, 3));
        end
    endtask

    // Damage a well-formed literal in one of several ways.
    task automatic break_literal();
        int unsigned     pos;
        rnlc_pkg::char_t junk[6];
        junk = '{rnlc_pkg::CH_POINT, rnlc_pkg::CH_LOWER_E, rnlc_pkg::CH_UPPER_E,
                 rnlc_pkg::CH_PLUS, rnlc_pkg::CH_MINUS, rnlc_pkg::CH_ZERO};
        pos = $urandom_range(0, word_q.size() - 1);
        case ($urandom_range(0, 3))
            0: word_q[pos] = rnlc_pkg::char_t'($urandom_range(0, 255));
            1: word_q[pos] = junk[$urandom_range(0, 5)];
            2: if (word_q.size() > 1) word_q = word_q[0:pos];
            default: word_q.insert(pos, junk[$urandom_range(0, 5)]);
        endcase
    endtask

    // ------------------------------------------------------------------
    // Receiver: own stall pattern in a randomly picked mode, plus a
    // long hold-off counted here whenever the sender asks for one.
    // ------------------------------------------------------------------
    initial begin
        int unsigned cyc;
        int unsigned mode;
        int          holds_served;
        cyc          = 0;
        mode         = 0;
        holds_served = 0;
        m_ready      = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_reqs != holds_served) begin
                holds_served++;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (cyc % 64 == 0) mode = $urandom_range(0, 3);
                case (mode)
                    0: m_ready = 1'b1;                          // no stalls
                    1: m_ready = 1'($urandom_range(0, 1));      // coin flip
                    2: m_ready = (cyc % 4) != 3;                // fixed pattern
                    default: m_ready = ($urandom_range(0, 3) == 0);  // mostly stalled
                endcase
                cyc++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: far beyond the slowest correct run.
    // ------------------------------------------------------------------
    initial begin
        #200000;
        $display("Timeout: verdicts still expected %0d", sb.expected_verdicts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned pick;
        int          leftover;
        bit          hold1_done;
        bit          drain_done;
        bit          hold2_done;
        int          target;

        sb          = new();
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_symbol    = '0;
        s_last_char = 1'b0;
        chars_sent  = 0;
        burst_left  = $urandom_range(1, 12);
        hold1_done  = 1'b0;
        drain_done  = 1'b0;
        hold2_done  = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part: bare zero, signs, fraction, exponent with sign,
        // zero followed by a digit, dead state absorbing bytes, lone point,
        // exponent led by zero, lone sign, zero byte and all-ones byte.
        send_text("0");
        send_text("-0.5");
        send_text("1e+9");
        send_text("2.5E-3");
        send_text("001");
        send_text(".");
        send_text("1e0");
        send_text("+");
        word_q.push_back(8'h00);
        send_word();
        word_q.push_back(8'hFF);
        send_word();

        // Random part: mostly well-formed literals, some damaged, some noise.
        target = chars_sent + RANDOM_CHARS;
        while (chars_sent < target) begin
            // long receiver hold-off while requests keep coming
            if (!hold1_done && chars_sent > target - RANDOM_CHARS * 3 / 4) begin
                hold1_done = 1'b1;
                hold_reqs++;
            end
            // sender pause until every owed verdict has come back
            if (!drain_done && chars_sent > target - RANDOM_CHARS / 2) begin
                drain_done = 1'b1;
                @(negedge aclk);
                s_valid = 1'b0;
                while (sb.expected_verdicts.size() != 0) @(posedge aclk);
            end
            if (!hold2_done && chars_sent > target - RANDOM_CHARS / 4) begin
                hold2_done = 1'b1;
                hold_reqs++;
            end

            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                build_literal();
            end else if (pick < 9) begin
                build_literal();
                break_literal();
            end else begin
                repeat ($urandom_range(1, 6))
                    word_q.push_back(rnlc_pkg::char_t'($urandom_range(0, 255)));
            end
            send_word();
        end

        // Drain, then allow a margin for late verdicts.
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_verdicts.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        leftover = sb.expected_verdicts.size();
        if (leftover != 0) begin
            $display("ERROR: %0d verdicts never arrived", leftover);
            sb.errors += leftover;
        end

        $display("Sent %0d characters in %0d strings; %0d verdicts checked, %0d valid literals.",
                 sb.chars_seen, sb.strings_seen, sb.verdicts_checked, sb.literals_accepted);
        $display("Included long output hold-offs, a full drain pause and random gaps; %0d errors.",
                 sb.errors);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
